[rtl/slru_pkg.sv]
// ----------------------------------------------------------------------------
// slru_pkg - shared types and codes of the sectioned LRU stack
// Word layouts of both channels, op and error codes, register indexes.
// ----------------------------------------------------------------------------
package slru_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int SLOT_W      = 4;
    localparam int SLOT_COUNT  = 16;
    localparam int CFG_W       = 5;
    localparam int COUNT_OUT_W = 5;
    // wide enough for any 1-based position up to the largest stack plus one
    localparam int POS_W       = 8;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TOUCH  = 2'd2;

    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_DUP    = 2'd1;
    localparam logic [1:0] ERR_ABSENT = 2'd2;
    localparam logic [1:0] ERR_FULL   = 2'd3;

    localparam logic CFG_NEW_COUNT = 1'b0;
    localparam logic CFG_OLD_START = 1'b1;

    typedef struct packed {
        logic [1:0]        op;
        logic [SLOT_W-1:0] slot;
    } t_in_word;

    typedef struct packed {
        logic                   was_new;
        logic                   was_old;
        logic [SLOT_W-1:0]      lru_slot;
        logic                   lru_valid;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic [1:0]             error;
    } t_out_word;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic              shift_left;   // insert: every cell takes its left neighbor
        logic              touch;        // touch: cells up to the hit take left neighbor
        logic              remove;       // remove: cells from the hit take right neighbor
        logic [SLOT_W-1:0] key;
    } t_cell_ctl;

endpackage

[rtl/slru_cell.sv]
// ----------------------------------------------------------------------------
// slru_cell - one recency position of the stack
// Holds one slot number, matches it against the key and shifts with its
// neighbors on insert, touch and remove.
// ----------------------------------------------------------------------------
module slru_cell
    import slru_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [CNT_W-1:0]  i_count,
    input  logic [CFG_W-1:0]  i_new_count,
    input  logic [CFG_W-1:0]  i_old_start,
    input  logic [SLOT_W-1:0] i_left_slot,
    input  logic [SLOT_W-1:0] i_right_slot,
    input  logic              i_seen,
    output logic              o_seen,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_hit_new,
    output logic              o_hit_old,
    output logic              o_last_hit,
    output logic [SLOT_W-1:0] o_last_slot,
    output logic [SLOT_W-1:0] o_prev_slot
);

    localparam logic [POS_W-1:0] POS = POS_W'(INDEX + 1);

    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic [POS_W-1:0]  w_count;
    logic              w_held;
    logic              w_match;
    logic              w_last;
    logic              w_prev;

    assign w_count = POS_W'(i_count);
    assign w_held  = POS <= w_count;
    assign w_match = w_held && (r_slot == i_ctl.key);
    assign w_last  = POS == w_count;
    assign w_prev  = (POS + POS_W'(1)) == w_count;

    assign o_seen      = i_seen | w_match;
    assign o_slot      = r_slot;
    assign o_hit_new   = w_match && (POS <= POS_W'(i_new_count));
    assign o_hit_old   = w_match && (POS >= POS_W'(i_old_start));
    assign o_last_hit  = w_match && w_last;
    assign o_last_slot = w_last ? r_slot : '0;
    assign o_prev_slot = w_prev ? r_slot : '0;

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.shift_left) begin
            n_slot = i_left_slot;
        end else if (i_ctl.touch && !i_seen) begin
            // at or above the hit: move one toward the tail
            n_slot = i_left_slot;
        end else if (i_ctl.remove && o_seen) begin
            // at or below the hit: close the gap
            n_slot = i_right_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

endmodule

[rtl/sectioned_lru_stack.sv]
// ----------------------------------------------------------------------------
// sectioned_lru_stack - recency stack with new / middle / old sections
// Keeps cache slots in recency order in a row of cells, most recent first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word): op and slot.
//   Output channel (o_out_valid / i_out_stall / o_out_word): one result word
//   per input word, in order.
//   Config port: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (new_count, old_start); write only while the block is idle.
// Latency and throughput:
//   One word per cycle unless stalled. The cell row updates every position in
//   the cycle the word is taken; the result word shows the next cycle from the
//   output register. The critical path is the hit chain through all ENTRIES cells.
// Reset:
//   i_rst_n low clears the slot-held flags and count, empties the output
//   register and loads new_count 4 and old_start 13.
// Stall:
//   While a result word is held under i_out_stall, o_in_stall is raised and
//   no new word is taken; the held result does not change.
// ----------------------------------------------------------------------------
module sectioned_lru_stack
    import slru_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_word,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [SLOT_COUNT-1:0] r_present;
    logic [SLOT_COUNT-1:0] n_present;
    logic [CFG_W-1:0]      r_new_count;
    logic [CFG_W-1:0]      r_old_start;
    logic                  r_out_valid;
    t_out_word             r_out_word;
    t_out_word             n_out_word;

    t_cell_ctl             w_ctl;
    logic                  w_accept;
    logic                  w_present;
    logic                  w_full;
    logic                  w_commit;
    logic [1:0]            w_err;
    logic [SLOT_W-1:0]     w_lru;

    logic [ENTRIES:0]      w_seen;
    logic [SLOT_W-1:0]     w_slot      [ENTRIES];
    logic [ENTRIES-1:0]    w_hit_new;
    logic [ENTRIES-1:0]    w_hit_old;
    logic [ENTRIES-1:0]    w_last_hit;
    logic [SLOT_W-1:0]     w_last_slot [ENTRIES];
    logic [SLOT_W-1:0]     w_prev_slot [ENTRIES];
    logic [SLOT_W-1:0]     w_last;
    logic [SLOT_W-1:0]     w_prev;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign w_present = r_present[i_in_word.slot];
    assign w_full    = r_count >= CNT_W'(ENTRIES);
    assign w_seen[0] = 1'b0;

    // error code and whether the state changes
    always_comb begin
        w_err    = ERR_OK;
        w_commit = 1'b0;
        case (i_in_word.op)
            OP_INSERT: begin
                if (w_present) begin
                    w_err = ERR_DUP;
                end else if (w_full) begin
                    w_err = ERR_FULL;
                end else begin
                    w_commit = 1'b1;
                end
            end
            OP_REMOVE, OP_TOUCH: begin
                if (!w_present) begin
                    w_err = ERR_ABSENT;
                end else begin
                    w_commit = 1'b1;
                end
            end
            default: begin
                w_err    = ERR_OK;
                w_commit = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_ctl.key        = i_in_word.slot;
        w_ctl.shift_left = w_accept && w_commit && (i_in_word.op == OP_INSERT);
        w_ctl.remove     = w_accept && w_commit && (i_in_word.op == OP_REMOVE);
        w_ctl.touch      = w_accept && w_commit && (i_in_word.op == OP_TOUCH);
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic [SLOT_W-1:0] w_left;
        logic [SLOT_W-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = i_in_word.slot;
        end else begin : g_body
            assign w_left = w_slot[g-1];
        end
        if (g == ENTRIES - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_slot[g+1];
        end

        slru_cell #(
            .INDEX (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_count      (r_count),
            .i_new_count  (r_new_count),
            .i_old_start  (r_old_start),
            .i_left_slot  (w_left),
            .i_right_slot (w_right),
            .i_seen       (w_seen[g]),
            .o_seen       (w_seen[g+1]),
            .o_slot       (w_slot[g]),
            .o_hit_new    (w_hit_new[g]),
            .o_hit_old    (w_hit_old[g]),
            .o_last_hit   (w_last_hit[g]),
            .o_last_slot  (w_last_slot[g]),
            .o_prev_slot  (w_prev_slot[g])
        );
    end

    always_comb begin
        w_last = '0;
        w_prev = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            w_last = w_last | w_last_slot[k];
            w_prev = w_prev | w_prev_slot[k];
        end
    end

    // tail slot after the step, from the current row
    always_comb begin
        w_lru = w_last;
        if (w_commit) begin
            case (i_in_word.op)
                OP_INSERT: begin
                    if (r_count == '0) begin
                        w_lru = i_in_word.slot;
                    end
                end
                OP_REMOVE: begin
                    if (|w_last_hit) begin
                        w_lru = w_prev;
                    end
                end
                OP_TOUCH: begin
                    if (|w_last_hit) begin
                        w_lru = (r_count == CNT_W'(1)) ? i_in_word.slot : w_prev;
                    end
                end
                default: begin
                    w_lru = w_last;
                end
            endcase
        end
    end

    always_comb begin
        n_count   = r_count;
        n_present = r_present;
        if (w_ctl.shift_left) begin
            n_count                   = r_count + CNT_W'(1);
            n_present[i_in_word.slot] = 1'b1;
        end else if (w_ctl.remove) begin
            n_count                   = r_count - CNT_W'(1);
            n_present[i_in_word.slot] = 1'b0;
        end
    end

    always_comb begin
        n_out_word.was_new     = |w_hit_new;
        n_out_word.was_old     = |w_hit_old;
        n_out_word.lru_slot    = w_lru;
        n_out_word.entry_count = COUNT_OUT_W'(n_count);
        n_out_word.lru_valid   = n_count != '0;
        n_out_word.error       = w_err;
        // count moves only on a committed insert or remove
        if (!w_commit) begin
            n_out_word.entry_count = COUNT_OUT_W'(r_count);
            n_out_word.lru_valid   = r_count != '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_present   <= '0;
            r_new_count <= CFG_W'(4);
            r_old_start <= CFG_W'(13);
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count   <= n_count;
                r_present <= n_present;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NEW_COUNT: r_new_count <= i_cfg_data;
                    CFG_OLD_START: r_old_start <= i_cfg_data;
                    default:       r_new_count <= r_new_count;
                endcase
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result word while stalled
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_word <= n_out_word;
        end
    end

endmodule
